// ===== hw/rtl/tac_pkg.sv =====
// ----------------------------------------------------------------------------
// tac_pkg - shared types and codes for the tiny accumulator machine
// Instruction and function codes, and the packed transaction types of both
// channels.
// ----------------------------------------------------------------------------
`default_nettype none

package tac_pkg;

	localparam int MEM_WORDS = 16;
	localparam int ADDR_W    = $clog2(MEM_WORDS);

	// function codes of an input transaction
	localparam logic [1:0] FUNC_LOAD    = 2'd0;
	localparam logic [1:0] FUNC_EXEC    = 2'd1;
	localparam logic [1:0] FUNC_RESTART = 2'd2;

	// opcodes (top nibble of an instruction byte)
	localparam logic [3:0] OP_NOP = 4'd0;
	localparam logic [3:0] OP_LDA = 4'd1;
	localparam logic [3:0] OP_ADD = 4'd2;
	localparam logic [3:0] OP_SUB = 4'd3;
	localparam logic [3:0] OP_STA = 4'd4;
	localparam logic [3:0] OP_LDI = 4'd5;
	localparam logic [3:0] OP_JMP = 4'd6;
	localparam logic [3:0] OP_JC  = 4'd7;
	localparam logic [3:0] OP_JZ  = 4'd8;
	localparam logic [3:0] OP_OUT = 4'd14;
	localparam logic [3:0] OP_HLT = 4'd15;

	typedef struct packed {
		logic [1:0] func;
		logic [3:0] load_addr;
		logic [7:0] load_data;
	} in_item_t;

	typedef struct packed {
		logic [7:0] acc_value;
		logic [7:0] b_value;
		logic [3:0] prog_counter;
		logic       zero_flag;
		logic       carry_flag;
		logic       halted;
		logic       out_valid;
		logic [7:0] out_value;
	} out_item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tiny_accumulator_cpu_step.sv =====
// ----------------------------------------------------------------------------
// tiny_accumulator_cpu_step - one step of an 8-bit accumulator machine
// Loads a memory byte, restarts the machine or runs one instruction for each
// input transaction, and returns the machine state after it.
// ----------------------------------------------------------------------------
// Each input is registered in the input stage, then in the result register.
// Throughput: 1 transaction per cycle while out_stall is low; fetch, operand
//   read and execute run in one pass over the 16-byte flip-flop memory between input and result regs.
// Reset: arst_n clears the pipeline valids, registers, flags, pc and memory.
`default_nettype none

module tiny_accumulator_cpu_step import tac_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire in_item_t  in_item,
	output logic           out_valid,
	input  wire logic      out_stall,
	output out_item_t      out_item
);

	logic              valid_s1;
	in_item_t          item_s1;
	logic              res_valid_q;
	out_item_t         res_q;

	logic [7:0]        mem_q [MEM_WORDS];
	logic [7:0]        acc_q;
	logic [7:0]        b_q;
	logic [ADDR_W-1:0] pc_q;
	logic              zero_q;
	logic              carry_q;
	logic              halt_q;

	logic              advance;
	logic [7:0]        word;
	logic [3:0]        op;
	logic [ADDR_W-1:0] arg;
	logic [7:0]        mv;
	logic [7:0]        rhs;
	logic              cin;
	logic [8:0]        sum;
	logic [7:0]        acc_d;
	logic [7:0]        b_d;
	logic [ADDR_W-1:0] pc_d;
	logic              zero_d;
	logic              carry_d;
	logic              halt_d;
	logic              shown;
	logic              jump;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_wa;
	logic [7:0]        mem_wd;

	// the result stage moves on when it is empty or its transaction leaves
	assign advance  = !res_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= in_item;
		end
	end

	// fetch and operand read
	assign word = mem_q[pc_q];
	assign op   = word[7:4];
	assign arg  = word[ADDR_W-1:0];
	assign mv   = mem_q[arg];
	assign rhs  = (op == OP_SUB) ? ~mv : mv;
	assign cin  = (op == OP_SUB);
	assign sum  = {1'b0, acc_q} + {1'b0, rhs} + {8'd0, cin};

	always_comb begin
		acc_d   = acc_q;
		b_d     = b_q;
		pc_d    = pc_q;
		zero_d  = zero_q;
		carry_d = carry_q;
		halt_d  = halt_q;
		shown   = 1'b0;
		jump    = 1'b0;
		mem_we  = 1'b0;
		mem_wa  = item_s1.load_addr[ADDR_W-1:0];
		mem_wd  = item_s1.load_data;
		priority if (item_s1.func == FUNC_LOAD) begin
			mem_we = 1'b1;
		end else if (item_s1.func == FUNC_RESTART) begin
			acc_d   = 8'd0;
			b_d     = 8'd0;
			pc_d    = '0;
			zero_d  = 1'b0;
			carry_d = 1'b0;
			halt_d  = 1'b0;
		end else if (item_s1.func == FUNC_EXEC && !halt_q) begin
			unique case (op)
				OP_LDA: begin
					acc_d  = mv;
					zero_d = (mv == 8'd0);
				end
				OP_ADD, OP_SUB: begin
					b_d     = mv;
					acc_d   = sum[7:0];
					carry_d = sum[8];
					zero_d  = (sum[7:0] == 8'd0);
				end
				OP_STA: begin
					mem_we = 1'b1;
					mem_wa = arg;
					mem_wd = acc_q;
				end
				OP_LDI: begin
					acc_d  = {4'd0, word[3:0]};
					zero_d = (word[3:0] == 4'd0);
				end
				OP_JMP:  jump = 1'b1;
				OP_JC:   jump = carry_q;
				OP_JZ:   jump = zero_q;
				OP_OUT:  shown = 1'b1;
				OP_HLT:  halt_d = 1'b1;
				default: ;
			endcase
			pc_d = jump ? arg : pc_q + ADDR_W'(1);
		end else begin
			// unused function code: hold everything
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= 8'd0;
			b_q     <= 8'd0;
			pc_q    <= '0;
			zero_q  <= 1'b0;
			carry_q <= 1'b0;
			halt_q  <= 1'b0;
			for (int i = 0; i < MEM_WORDS; i++) begin
				mem_q[i] <= 8'd0;
			end
		end else if (valid_s1 && advance) begin
			acc_q   <= acc_d;
			b_q     <= b_d;
			pc_q    <= pc_d;
			zero_q  <= zero_d;
			carry_q <= carry_d;
			halt_q  <= halt_d;
			if (mem_we) begin
				mem_q[mem_wa] <= mem_wd;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_q.acc_value    <= acc_d;
			res_q.b_value      <= b_d;
			res_q.prog_counter <= pc_d;
			res_q.zero_flag    <= zero_d;
			res_q.carry_flag   <= carry_d;
			res_q.halted       <= halt_d;
			res_q.out_valid    <= shown;
			res_q.out_value    <= shown ? acc_q : 8'd0;
		end
	end

	assign out_valid = res_valid_q;
	assign out_item  = res_q;

	// stall only ever holds a transaction that is waiting in the input stage
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stall raised with an empty input stage");

	// executing while halted leaves the machine untouched
	a_halt_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && halt_q && item_s1.func == FUNC_EXEC)
		|=> ($stable(pc_q) && $stable(acc_q) && $stable(b_q) && halt_q))
		else $error("machine state changed while halted");

	// restart clears registers, pc and halt
	a_restart_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && item_s1.func == FUNC_RESTART)
		|=> (acc_q == 8'd0 && b_q == 8'd0 && pc_q == '0 && !halt_q))
		else $error("restart did not clear the machine");

	// an out step shows A, which it does not change
	a_out_shows_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.out_valid) |-> (res_q.out_value == res_q.acc_value))
		else $error("shown value differs from register A");

endmodule

`default_nettype wire

// ===== dv/tiny_accumulator_cpu_step_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tiny_accumulator_cpu_step_test - self-checking bench for the accumulator step
// Runs a hand-built program over every opcode but NOP, the halt, restart and unused
// function cases, then many random programs under varying idle and stall
// patterns and one long output hold-off. A shadow machine predicts the state
// after each input transaction. Every result is compared with it field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tiny_accumulator_cpu_step_test import tac_pkg::*;;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int         CYCLE_LIMIT = 100000;
	localparam int         HOLD_OFF    = 300;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_item_t out_item;

	// shadow copy of the machine
	logic [7:0] shadow_mem [MEM_WORDS];
	logic [7:0] shadow_a;
	logic [7:0] shadow_b;
	logic [3:0] shadow_pc;
	logic       shadow_zero;
	logic       shadow_carry;
	logic       shadow_halt;

	out_item_t expected_states [$];

	int send_idle_pct;
	int stall_pct;
	int hold_off_left;
	int cycle_count;
	int errors;
	int results_checked;
	int items_sent;
	int instr_count;
	int jumps_taken;
	int out_count;
	int halt_count;

	tiny_accumulator_cpu_step u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_count);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// receiver: random stalls, or a counted hold-off when one is requested
	always @(negedge clk) begin
		if (hold_off_left > 0) begin
			out_stall     <= 1'b1;
			hold_off_left <= hold_off_left - 1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// work out the machine state after one accepted transaction
	task automatic execute_step(input in_item_t it);
		out_item_t  res;
		logic [7:0] word;
		logic [7:0] opnd;
		logic [3:0] op;
		logic [3:0] arg;
		logic [8:0] sum;
		logic       taken;

		res = '0;
		case (it.func)
			FUNC_LOAD: shadow_mem[it.load_addr] = it.load_data;
			FUNC_RESTART: begin
				shadow_a     = '0;
				shadow_b     = '0;
				shadow_pc    = '0;
				shadow_zero  = 1'b0;
				shadow_carry = 1'b0;
				shadow_halt  = 1'b0;
			end
			FUNC_EXEC: if (!shadow_halt) begin
				word  = shadow_mem[shadow_pc];
				op    = word[7:4];
				arg   = word[3:0];
				opnd  = shadow_mem[arg];
				taken = 1'b0;
				instr_count++;
				case (op)
					OP_LDA: begin
						shadow_a    = opnd;
						shadow_zero = (shadow_a == 8'h00);
					end
					OP_ADD, OP_SUB: begin
						shadow_b = opnd;
						if (op == OP_ADD)
							sum = {1'b0, shadow_a} + {1'b0, shadow_b};
						else
							sum = {1'b0, shadow_a} + {1'b0, ~shadow_b} + 9'd1;
						shadow_a     = sum[7:0];
						shadow_carry = sum[8];
						shadow_zero  = (shadow_a == 8'h00);
					end
					OP_STA: shadow_mem[arg] = shadow_a;
					OP_LDI: begin
						shadow_a    = {4'h0, arg};
						shadow_zero = (shadow_a == 8'h00);
					end
					OP_JMP: taken = 1'b1;
					OP_JC:  taken = shadow_carry;
					OP_JZ:  taken = shadow_zero;
					OP_OUT: begin
						res.out_valid = 1'b1;
						res.out_value = shadow_a;
						out_count++;
					end
					OP_HLT: begin
						shadow_halt = 1'b1;
						halt_count++;
					end
					default: ;
				endcase
				if (taken)
					jumps_taken++;
				shadow_pc = taken ? arg : shadow_pc + 4'd1;
			end
			default: ;
		endcase
		res.acc_value    = shadow_a;
		res.b_value      = shadow_b;
		res.prog_counter = shadow_pc;
		res.zero_flag    = shadow_zero;
		res.carry_flag   = shadow_carry;
		res.halted       = shadow_halt;
		expected_states.push_back(res);
	endtask

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : check_results
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_states.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, got %p", $time, out_item);
			end else begin
				want = expected_states.pop_front();
				check_field("acc_value", want.acc_value, out_item.acc_value);
				check_field("b_value", want.b_value, out_item.b_value);
				check_field("prog_counter", 8'(want.prog_counter),
					8'(out_item.prog_counter));
				check_field("zero_flag", 8'(want.zero_flag), 8'(out_item.zero_flag));
				check_field("carry_flag", 8'(want.carry_flag), 8'(out_item.carry_flag));
				check_field("halted", 8'(want.halted), 8'(out_item.halted));
				check_field("out_valid", 8'(want.out_valid), 8'(out_item.out_valid));
				check_field("out_value", want.out_value, out_item.out_value);
				results_checked++;
			end
		end
	end

	// offer one transaction from a falling edge; return at the falling edge after it is taken
	task automatic send_item(input in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		do @(posedge clk); while (in_stall);
		execute_step(it);
		items_sent++;
		@(negedge clk);
	endtask

	function automatic in_item_t make_item(input logic [1:0] f, input logic [3:0] a,
			input logic [7:0] d);
		in_item_t it;
		it.func      = f;
		it.load_addr = a;
		it.load_data = d;
		return it;
	endfunction

	task automatic send_load(input logic [3:0] a, input logic [7:0] d);
		send_item(make_item(FUNC_LOAD, a, d));
	endtask

	// the address and data fields carry noise on non-load transactions
	task automatic send_cmd(input logic [1:0] f);
		send_item(make_item(f, 4'($urandom_range(15)), 8'($urandom_range(255))));
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (expected_states.size() != 0)
			@(negedge clk);
	endtask

	// mostly meaningful opcodes; raw bytes keep every data bit moving
	function automatic logic [7:0] random_mem_byte();
		logic [3:0] op;
		case ($urandom_range(11))
			0, 1, 2: op = 4'($urandom_range(15));
			3:       op = OP_LDA;
			4:       op = OP_ADD;
			5:       op = OP_SUB;
			6:       op = OP_STA;
			7:       op = OP_LDI;
			8:       op = OP_JMP;
			9:       op = OP_JC;
			10:      op = OP_JZ;
			default: op = OP_OUT;
		endcase
		if ($urandom_range(3) == 0)
			return 8'($urandom_range(255));
		return {op, 4'($urandom_range(15))};
	endfunction

	task automatic run_random_program(input int steps);
		int k;
		int r;
		for (k = 0; k < MEM_WORDS; k++)
			send_load(k[3:0], random_mem_byte());
		if ($urandom_range(9) != 0)
			send_cmd(FUNC_RESTART);
		for (k = 0; k < steps; k++) begin
			r = $urandom_range(99);
			if (r < 4)
				send_load(4'($urandom_range(15)), 8'($urandom_range(255)));
			else if (r < 7)
				send_cmd(FUNC_UNUSED);
			else if (r < 9)
				send_cmd(FUNC_RESTART);
			else
				send_cmd(FUNC_EXEC);
		end
	endtask

	// program touching every opcode but NOP, plus an unused one, with every jump kind taken
	task automatic test_every_opcode();
		send_load(4'd15, 8'hff);
		send_load(4'd14, 8'h01);
		send_load(4'd0,  {OP_LDA, 4'd15});
		send_load(4'd1,  {OP_ADD, 4'd14});
		send_load(4'd2,  {OP_JC,  4'd4});
		send_load(4'd4,  {OP_JZ,  4'd7});
		send_load(4'd7,  {OP_SUB, 4'd15});
		send_load(4'd8,  {OP_STA, 4'd3});
		send_load(4'd9,  {OP_LDI, 4'd15});
		send_load(4'd10, {OP_OUT, 4'd0});
		send_load(4'd11, {OP_JMP, 4'd12});
		send_load(4'd12, 8'hb3);
		send_load(4'd13, {OP_HLT, 4'd0});
		repeat (11)
			send_cmd(FUNC_EXEC);
		wait_idle();
	endtask

	// halted machine ignores execution, still takes loads; restart keeps memory
	task automatic test_halt_and_restart();
		send_cmd(FUNC_EXEC);
		send_load(4'd0, 8'h00);
		send_cmd(FUNC_UNUSED);
		send_cmd(FUNC_RESTART);
		send_cmd(FUNC_EXEC);
		send_cmd(FUNC_EXEC);
		wait_idle();
	endtask

	task automatic test_random_programs(input int sender_idle, input int receiver_stall,
			input int programs);
		send_idle_pct = sender_idle;
		stall_pct     = receiver_stall;
		repeat (programs)
			run_random_program($urandom_range(8, 40));
		wait_idle();
	endtask

	// hold the output off long enough for the block to fill and stall its input
	task automatic test_output_hold_off();
		send_idle_pct = 0;
		stall_pct     = 0;
		@(posedge clk);
		hold_off_left = HOLD_OFF;
		@(negedge clk);
		run_random_program(40);
		wait_idle();
	endtask

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		in_item       = '0;
		send_idle_pct = 27;
		stall_pct     = 70;
		hold_off_left = 0;
		cycle_count   = 0;
		errors        = 0;
		foreach (shadow_mem[i])
			shadow_mem[i] = '0;
		shadow_a     = '0;
		shadow_b     = '0;
		shadow_pc    = '0;
		shadow_zero  = 1'b0;
		shadow_carry = 1'b0;
		shadow_halt  = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_every_opcode();
		test_halt_and_restart();
		test_random_programs(27, 70, 12);
		test_random_programs(70, 27, 12);
		test_random_programs(0, 0, 12);
		test_output_hold_off();

		repeat (8) @(posedge clk);
		$display("Sent %0d transactions: %0d instructions run, %0d jumps taken, %0d out, %0d halts.",
			items_sent, instr_count, jumps_taken, out_count, halt_count);
		$display("Checked %0d results with %0d mismatches.", results_checked, errors);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire
